/* rtl/core/trif_pkg.sv */
// shared types, constants and helper function of the triangle fill rasterizer
`timescale 1ns / 1ps

package trif_pkg;

	// coordinate width and the widths that follow from it
	localparam int CW   = 12;
	localparam int DW   = CW + 1;
	localparam int PW   = CW + DW;
	localparam int CPW  = 2 * CW;
	localparam int DETW = 2 * CW + 3;
	localparam int SUMW = 2 * CW + 4;

	// colour widths
	localparam int RGB_W   = 24;
	localparam int COLOR_W = 16;

	// configuration port
	localparam int CFG_W     = 24;
	localparam int REG_IDX_W = 3;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_VERTEX1_X = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_VERTEX1_Y = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_VERTEX2_X = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_VERTEX2_Y = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_VERTEX3_X = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_VERTEX3_Y = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_FILL_RGB  = 3'd6;

	typedef logic signed [CW-1:0] coord_t;

	// the three configured vertices
	typedef struct packed {
		coord_t x1;
		coord_t y1;
		coord_t x2;
		coord_t y2;
		coord_t x3;
		coord_t y3;
	} vert_t;

	// one emitted pixel as it moves down the pipeline
	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   idle;
		logic   last;
	} pix_t;

	// load enables of the coverage stages
	typedef struct packed {
		logic s2;
		logic s3;
	} stage_en_t;

	// pack 8:8:8 colour into 5:6:5
	function automatic logic [COLOR_W-1:0] rgb565(input logic [RGB_W-1:0] rgb);
		rgb565 = {rgb[23:19], rgb[15:10], rgb[7:3]};
	endfunction

endpackage

/* rtl/core/trif_scan.sv */
// bounding box setup and row-major scan counters
`timescale 1ns / 1ps

module trif_scan (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic            restart,
	input  trif_pkg::vert_t vert,
	output trif_pkg::pix_t  pix
);

	trif_pkg::coord_t scan_x_q, scan_y_q, left_q, right_q, bottom_q;
	logic             scanning_q;

	trif_pkg::coord_t min_x, max_x, min_y, max_y;
	trif_pkg::coord_t cur_x, cur_y, left, right, bottom;
	logic             active, row_end, fin;

	function automatic trif_pkg::coord_t min3(input trif_pkg::coord_t a,
		input trif_pkg::coord_t b, input trif_pkg::coord_t c);
		trif_pkg::coord_t m;
		m    = (a < b) ? a : b;
		min3 = (m < c) ? m : c;
	endfunction

	function automatic trif_pkg::coord_t max3(input trif_pkg::coord_t a,
		input trif_pkg::coord_t b, input trif_pkg::coord_t c);
		trif_pkg::coord_t m;
		m    = (a > b) ? a : b;
		max3 = (m > c) ? m : c;
	endfunction

	// box of the vertices, used on a restart beat
	assign min_x = min3(vert.x1, vert.x2, vert.x3);
	assign max_x = max3(vert.x1, vert.x2, vert.x3);
	assign min_y = min3(vert.y1, vert.y2, vert.y3);
	assign max_y = max3(vert.y1, vert.y2, vert.y3);

	// position and bounds seen by this beat
	assign cur_x   = restart ? min_x : scan_x_q;
	assign cur_y   = restart ? min_y : scan_y_q;
	assign left    = restart ? min_x : left_q;
	assign right   = restart ? max_x : right_q;
	assign bottom  = restart ? max_y : bottom_q;
	assign active  = restart | scanning_q;
	assign row_end = cur_x >= right;
	assign fin     = row_end && (cur_y >= bottom);

	// emitted pixel, zeros with last when no scan runs
	always_comb begin
		pix.x    = active ? cur_x : '0;
		pix.y    = active ? cur_y : '0;
		pix.idle = ~active;
		pix.last = ~active | fin;
	end

	// scan state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_x_q   <= '0;
			scan_y_q   <= '0;
			left_q     <= '0;
			right_q    <= '0;
			bottom_q   <= '0;
			scanning_q <= 1'b0;
		end else if (accept) begin
			if (restart) begin
				left_q   <= min_x;
				right_q  <= max_x;
				bottom_q <= max_y;
			end
			scanning_q <= active & ~fin;
			// next pixel of the box, or the current position when the scan stops
			if (active && !fin) begin
				if (row_end) begin
					scan_x_q <= left;
					scan_y_q <= cur_y + trif_pkg::coord_t'(1);
				end else begin
					scan_x_q <= cur_x + trif_pkg::coord_t'(1);
					scan_y_q <= cur_y;
				end
			end else begin
				scan_x_q <= cur_x;
				scan_y_q <= cur_y;
			end
		end
	end

endmodule

/* rtl/core/trif_cover.sv */
// coverage test: products, determinants and exact area comparison
`timescale 1ns / 1ps

module trif_cover (
	input  logic                clk,
	input  trif_pkg::stage_en_t en,
	input  trif_pkg::coord_t    px,
	input  trif_pkg::coord_t    py,
	input  trif_pkg::vert_t     vert,
	output logic                covered
);

	typedef logic signed [trif_pkg::DW-1:0]   diff_t;
	typedef logic signed [trif_pkg::PW-1:0]   prod_t;
	typedef logic signed [trif_pkg::CPW-1:0]  cprod_t;
	typedef logic signed [trif_pkg::DETW-1:0] det_t;
	typedef logic        [trif_pkg::DETW-1:0] mag_t;

	diff_t a1, a2, a3, b1, b2, b3;

	prod_t  pa1_s2, pa2_s2, pa3_s2, pb1_s2, pb2_s2, pb3_s2;
	cprod_t c1p_s2, c1n_s2, c2p_s2, c2n_s2, c3p_s2, c3n_s2;

	det_t d1, d2, d3, d0;
	mag_t m1_s3, m2_s3, m3_s3, m0_s3;

	logic [trif_pkg::SUMW-1:0] msum;

	function automatic diff_t sub(input trif_pkg::coord_t a, input trif_pkg::coord_t b);
		sub = diff_t'(a) - diff_t'(b);
	endfunction

	function automatic mag_t mag(input det_t v);
		mag = v[trif_pkg::DETW-1] ? mag_t'(-v) : mag_t'(v);
	endfunction

	// edge coefficients from the vertices
	assign a1 = sub(vert.y2, vert.y3);
	assign b1 = sub(vert.x3, vert.x2);
	assign a2 = sub(vert.y3, vert.y1);
	assign b2 = sub(vert.x1, vert.x3);
	assign a3 = sub(vert.y1, vert.y2);
	assign b3 = sub(vert.x2, vert.x1);

	// product stage
	always_ff @(posedge clk) begin
		if (en.s2) begin
			pa1_s2 <= prod_t'(px) * prod_t'(a1);
			pb1_s2 <= prod_t'(py) * prod_t'(b1);
			pa2_s2 <= prod_t'(px) * prod_t'(a2);
			pb2_s2 <= prod_t'(py) * prod_t'(b2);
			pa3_s2 <= prod_t'(px) * prod_t'(a3);
			pb3_s2 <= prod_t'(py) * prod_t'(b3);
			c1p_s2 <= cprod_t'(vert.x2) * cprod_t'(vert.y3);
			c1n_s2 <= cprod_t'(vert.x3) * cprod_t'(vert.y2);
			c2p_s2 <= cprod_t'(vert.x3) * cprod_t'(vert.y1);
			c2n_s2 <= cprod_t'(vert.x1) * cprod_t'(vert.y3);
			c3p_s2 <= cprod_t'(vert.x1) * cprod_t'(vert.y2);
			c3n_s2 <= cprod_t'(vert.x2) * cprod_t'(vert.y1);
		end
	end

	// sub-triangle and triangle determinants
	always_comb begin
		d1 = det_t'(pa1_s2) + det_t'(pb1_s2) + det_t'(c1p_s2) - det_t'(c1n_s2);
		d2 = det_t'(pa2_s2) + det_t'(pb2_s2) + det_t'(c2p_s2) - det_t'(c2n_s2);
		d3 = det_t'(pa3_s2) + det_t'(pb3_s2) + det_t'(c3p_s2) - det_t'(c3n_s2);
		d0 = det_t'(c1p_s2) - det_t'(c1n_s2) + det_t'(c2p_s2) - det_t'(c2n_s2)
			+ det_t'(c3p_s2) - det_t'(c3n_s2);
	end

	// magnitude stage
	always_ff @(posedge clk) begin
		if (en.s3) begin
			m1_s3 <= mag(d1);
			m2_s3 <= mag(d2);
			m3_s3 <= mag(d3);
			m0_s3 <= mag(d0);
		end
	end

	// inside when the three areas add up exactly to the whole
	assign msum    = {1'b0, m1_s3} + {1'b0, m2_s3} + {1'b0, m3_s3};
	assign covered = msum == {1'b0, m0_s3};

endmodule

/* rtl/core/triangle_fill_rasterizer.sv */
// top level of the triangle fill rasterizer: registers, pipeline control, output beat
`timescale 1ns / 1ps

// Rasterizes one filled triangle held in seven write-only registers
// (three vertices, 12-bit signed each, and a 24-bit fill colour).
// Every input beat on s_axis yields exactly one pixel beat on m_axis.
// A beat with restart set loads the vertices' bounding box and emits its
// top-left corner; each later beat emits the next box pixel, x fastest,
// with tlast on the final pixel. With no scan running a beat gives
// pixel 0,0, not covered, tlast set. tuser carries the covered flag.
// An input beat passes the scan register, a product stage (twelve small
// multipliers), a determinant magnitude stage and the output register.
// Throughput is one pixel per cycle unless the receiver stalls, set by
// the single-step scan counters; every stage has its own valid, so empty
// stages keep filling while the receiver stalls, and tready drops only
// once all four stages hold beats. Reset clears the registers to zero,
// empties the pipeline and leaves the scan idle. Registers are to be
// written only while no beat is in flight: a user rule, not enforced.
module triangle_fill_rasterizer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [trif_pkg::REG_IDX_W-1:0]     wr_index,
	input  logic [trif_pkg::CFG_W-1:0]         wr_data,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [7:0]                         s_axis_tdata,  // restart, zero pad
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [39:0]                        m_axis_tdata,  // pixel_x, pixel_y, pixel_color
	output logic [0:0]                         m_axis_tuser,  // covered
	output logic                               m_axis_tlast
);

	trif_pkg::vert_t               vert_q;
	logic [trif_pkg::RGB_W-1:0]    fill_q;

	trif_pkg::pix_t      pix_in, pix_s1, pix_s2, pix_s3;
	logic                v_s1, v_s2, v_s3, v_out_q;
	logic                adv1, adv2, adv3, adv_out, accept;
	trif_pkg::stage_en_t en;
	logic                cov;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vert_q <= '0;
			fill_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				trif_pkg::REG_VERTEX1_X: vert_q.x1 <= wr_data[trif_pkg::CW-1:0];
				trif_pkg::REG_VERTEX1_Y: vert_q.y1 <= wr_data[trif_pkg::CW-1:0];
				trif_pkg::REG_VERTEX2_X: vert_q.x2 <= wr_data[trif_pkg::CW-1:0];
				trif_pkg::REG_VERTEX2_Y: vert_q.y2 <= wr_data[trif_pkg::CW-1:0];
				trif_pkg::REG_VERTEX3_X: vert_q.x3 <= wr_data[trif_pkg::CW-1:0];
				trif_pkg::REG_VERTEX3_Y: vert_q.y3 <= wr_data[trif_pkg::CW-1:0];
				trif_pkg::REG_FILL_RGB:  fill_q    <= wr_data[trif_pkg::RGB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// per-stage flow control
	assign adv_out       = ~v_out_q | m_axis_tready;
	assign adv3          = ~v_s3 | adv_out;
	assign adv2          = ~v_s2 | adv3;
	assign adv1          = ~v_s1 | adv2;
	assign s_axis_tready = adv1;
	assign accept        = s_axis_tvalid & s_axis_tready;
	assign en.s2         = adv2;
	assign en.s3         = adv3;
	assign m_axis_tvalid = v_out_q;

	trif_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.restart (s_axis_tdata[0]),
		.vert    (vert_q),
		.pix     (pix_in)
	);

	trif_cover u_cover (
		.clk     (clk),
		.en      (en),
		.px      (pix_s1.x),
		.py      (pix_s1.y),
		.vert    (vert_q),
		.covered (cov)
	);

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (adv1)    v_s1    <= s_axis_tvalid;
			if (adv2)    v_s2    <= v_s1;
			if (adv3)    v_s3    <= v_s2;
			if (adv_out) v_out_q <= v_s3;
		end
	end

	// pixel payload alongside the coverage stages
	always_ff @(posedge clk) begin
		if (adv1) pix_s1 <= pix_in;
		if (adv2) pix_s2 <= pix_s1;
		if (adv3) pix_s3 <= pix_s2;
	end

	// output beat register
	always_ff @(posedge clk) begin
		if (adv_out) begin
			m_axis_tdata    <= {trif_pkg::rgb565(fill_q), pix_s3.y, pix_s3.x};
			m_axis_tuser[0] <= cov & ~pix_s3.idle;
			m_axis_tlast    <= pix_s3.last;
		end
	end

endmodule
